[hw/rtl/assert_macros.svh]
// Assertion helpers for the hasher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SH_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`define SH_ASSERT(lbl, prop, msg) \
    `SH_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[hw/rtl/sha256sh_pkg.sv]
package sha256sh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       message_end;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // what follows a compression
    typedef enum logic [1:0] {
        AFT_DATA,
        AFT_PAD,
        AFT_ZEROS,
        AFT_DONE
    } t_after;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [1:0] LAST_IDX = 2'd3;

    localparam logic [31:0] IV_TAB [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

[hw/rtl/sha256_stream_hasher_top.sv]
// Byte in: words are taken while idle; a full 64-byte block then runs 64 rounds and a
// chain add in the single round unit, which sets the pace for a long message.
// Message end: padding feeds one byte per cycle (up to 72 with an extra block), and each
// pad block is hashed alike; the digest leaves as four words, one per cycle when taken.
// Not ready while hashing or showing the digest.
// Synchronous active-low reset: chain value to the initial hash, counts cleared, idle.
module sha256_stream_hasher_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  sha256sh_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output sha256sh_pkg::t_out_word o_out_word
);

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sm_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sm_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    sha256sh_pkg::t_state r_state, n_state;
    sha256sh_pkg::t_after r_after, n_after;
    logic [511:0] r_blk, n_blk;
    logic [31:0]  r_h [0:7];
    logic [31:0]  n_h [0:7];
    logic [31:0]  r_v [0:7];
    logic [31:0]  n_v [0:7];
    logic [63:0]  r_total, n_total;
    logic [63:0]  r_len, n_len;
    logic [5:0]   r_fill, n_fill;
    logic [5:0]   r_round, n_round;
    logic [1:0]   r_oidx, n_oidx;
    logic         r_first, n_first;
    logic         r_final, n_final;

    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [7:0]  pad_byte;

    // message schedule window: word t at the top of r_blk
    assign w_new = r_blk[511:480] + sm_s0(r_blk[479:448]) + r_blk[223:192]
                 + sm_s1(r_blk[63:32]);

    assign t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256sh_pkg::K_TAB[r_round] + r_blk[511:480];
    assign t2 = big_s0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        if (r_first) begin
            pad_byte = sha256sh_pkg::PAD_BYTE;
        end else if (r_final && (r_fill >= sha256sh_pkg::LEN_POS)) begin
            pad_byte = r_len[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_blk   = r_blk;
        n_total = r_total;
        n_len   = r_len;
        n_fill  = r_fill;
        n_round = r_round;
        n_oidx  = r_oidx;
        n_first = r_first;
        n_final = r_final;
        for (int i = 0; i < 8; i++) begin
            n_h[i] = r_h[i];
            n_v[i] = r_v[i];
        end
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        case (r_state)
            sha256sh_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_word.has_byte) begin
                        n_blk   = {r_blk[503:0], i_in_word.data_byte};
                        n_fill  = r_fill + 6'd1;
                        n_total = r_total + 64'd1;
                    end
                    if (i_in_word.has_byte && (r_fill == sha256sh_pkg::LAST_POS)) begin
                        n_state = sha256sh_pkg::ST_ROUND;
                        n_round = 6'd0;
                        for (int i = 0; i < 8; i++) begin
                            n_v[i] = r_h[i];
                        end
                        n_after = i_in_word.message_end ? sha256sh_pkg::AFT_PAD
                                                        : sha256sh_pkg::AFT_DATA;
                    end else if (i_in_word.message_end) begin
                        n_state = sha256sh_pkg::ST_PAD;
                        n_first = 1'b1;
                        n_final = (n_fill < sha256sh_pkg::LEN_POS);
                    end
                end
            end

            sha256sh_pkg::ST_PAD: begin
                n_blk   = {r_blk[503:0], pad_byte};
                n_fill  = r_fill + 6'd1;
                n_first = 1'b0;
                if (r_first) begin
                    n_len = {r_total[60:0], 3'b000};
                end else if (r_final && (r_fill >= sha256sh_pkg::LEN_POS)) begin
                    n_len = {r_len[55:0], 8'h00};
                end
                if (r_fill == sha256sh_pkg::LAST_POS) begin
                    n_state = sha256sh_pkg::ST_ROUND;
                    n_round = 6'd0;
                    for (int i = 0; i < 8; i++) begin
                        n_v[i] = r_h[i];
                    end
                    n_after = r_final ? sha256sh_pkg::AFT_DONE : sha256sh_pkg::AFT_ZEROS;
                end
            end

            sha256sh_pkg::ST_ROUND: begin
                n_blk   = {r_blk[479:0], w_new};
                n_round = r_round + 6'd1;
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = t1 + t2;
                if (r_round == sha256sh_pkg::LAST_POS) begin
                    n_state = sha256sh_pkg::ST_UPDATE;
                end
            end

            sha256sh_pkg::ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                case (r_after)
                    sha256sh_pkg::AFT_DATA: begin
                        n_state = sha256sh_pkg::ST_IDLE;
                    end
                    sha256sh_pkg::AFT_PAD: begin
                        n_state = sha256sh_pkg::ST_PAD;
                        n_first = 1'b1;
                        n_final = 1'b1;
                    end
                    sha256sh_pkg::AFT_ZEROS: begin
                        n_state = sha256sh_pkg::ST_PAD;
                        n_first = 1'b0;
                        n_final = 1'b1;
                    end
                    sha256sh_pkg::AFT_DONE: begin
                        n_state = sha256sh_pkg::ST_OUT;
                        n_oidx  = 2'd0;
                    end
                    default: begin
                        n_state = sha256sh_pkg::ST_IDLE;
                    end
                endcase
            end

            sha256sh_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_oidx = r_oidx + 2'd1;
                    for (int i = 0; i < 6; i++) begin
                        n_h[i] = r_h[i + 2];
                    end
                    if (r_oidx == sha256sh_pkg::LAST_IDX) begin
                        n_state = sha256sh_pkg::ST_IDLE;
                        n_total = 64'd0;
                        for (int i = 0; i < 8; i++) begin
                            n_h[i] = sha256sh_pkg::IV_TAB[i];
                        end
                    end
                end
            end

            default: begin
                n_state = sha256sh_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_word.digest_word = {r_h[0], r_h[1]};
    assign o_out_word.word_index  = r_oidx;
    assign o_out_word.last_word   = (r_oidx == sha256sh_pkg::LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256sh_pkg::ST_IDLE;
            r_after <= sha256sh_pkg::AFT_DATA;
            r_total <= 64'd0;
            r_fill  <= 6'd0;
            r_round <= 6'd0;
            r_oidx  <= 2'd0;
            r_first <= 1'b0;
            r_final <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256sh_pkg::IV_TAB[i];
            end
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_oidx  <= n_oidx;
            r_first <= n_first;
            r_final <= n_final;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= n_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_len <= n_len;
        for (int i = 0; i < 8; i++) begin
            r_v[i] <= n_v[i];
        end
    end

endmodule

[hw/rtl/sha256sh_checker.sv]
`include "assert_macros.svh"

module sha256sh_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input sha256sh_pkg::t_out_word o_out_word
);

    `SH_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)), "digest word dropped or changed while stalled")

    `SH_ASSERT(a_busy_excl, !(o_out_valid && o_in_ready), "input ready while digest pending")

    `SH_ASSERT(a_first_idx, $rose(o_out_valid) |-> (o_out_word.word_index == 2'd0), "digest does not start at word zero")

    `SH_ASSERT_CLK(a_idx_step, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_out_word.last_word) |=> (o_out_valid && (o_out_word.word_index == $past(o_out_word.word_index) + 2'd1)), "digest word index skipped")

    `SH_ASSERT(a_back_idle, (o_out_valid && i_out_ready && o_out_word.last_word) |=> (o_in_ready && !o_out_valid), "not idle after last digest word")

endmodule

bind sha256_stream_hasher_top sha256sh_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT_NS    = 5_000_000;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 300;
    localparam int ITEM_TARGET = 330;
    localparam int MSG_TARGET  = 12;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [1:0] FINAL_WORD   = 2'd3;
    localparam int         LEN_FIELD_AT = 56;

    localparam int EDGE_LENS [0:8] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    localparam logic [31:0] HASH_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    class sha256_digest_sb;
        logic [31:0] chain [0:7];
        logic [7:0]  blk [0:63];
        logic [63:0] byte_cnt;
        logic [6:0]  fill;
        sha256sh_pkg::t_out_word digests_due [$];
        int          messages;
        int          words_checked;
        int          errors;

        function new();
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
            messages = 0;
            words_checked = 0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = HASH_INIT[i];
            byte_cnt = '0;
            fill = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int unsigned s);
            return (x >> s) | (x << (32 - s));
        endfunction

        function void compress();
            logic [31:0] sch [0:63];
            logic [31:0] v [0:7];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
                sch[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                s0 = ror(sch[i-15], 7) ^ ror(sch[i-15], 18) ^ (sch[i-15] >> 3);
                s1 = ror(sch[i-2], 17) ^ ror(sch[i-2], 19) ^ (sch[i-2] >> 10);
                sch[i] = sch[i-16] + s0 + sch[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                     ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + sch[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                     ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void note_input(sha256sh_pkg::t_in_word wd);
            logic [63:0] bit_len;
            sha256sh_pkg::t_out_word dw;
            int          pos;
            if (wd.has_byte) begin
                blk[fill[5:0]] = wd.data_byte;
                fill = fill + 7'd1;
                byte_cnt = byte_cnt + 64'd1;
                if (fill >= 7'd64) begin
                    compress();
                    fill = '0;
                end
            end
            if (!wd.message_end) return;
            bit_len = byte_cnt << 3;
            pos = int'(fill[5:0]);
            blk[pos] = PAD_MARK;
            pos++;
            // no room for the length: pad out and spend an extra block
            if (pos > LEN_FIELD_AT) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < LEN_FIELD_AT) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++) blk[63 - i] = bit_len[8*i +: 8];
            compress();
            for (int k = 0; k < 4; k++) begin
                dw.digest_word = {chain[2*k], chain[2*k+1]};
                dw.word_index  = 2'(k);
                dw.last_word   = (2'(k) == FINAL_WORD);
                digests_due.push_back(dw);
            end
            messages++;
            restart();
        endfunction

        function void check_output(sha256sh_pkg::t_out_word got);
            sha256sh_pkg::t_out_word want;
            if (digests_due.size() == 0) begin
                $error("digest word with nothing expected: %h", got.digest_word);
                errors++;
                return;
            end
            want = digests_due.pop_front();
            words_checked++;
            if (got.digest_word !== want.digest_word) begin
                $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index) begin
                $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %0d, got %0d", want.last_word, got.last_word);
                errors++;
            end
        endfunction

        function int pending();
            return digests_due.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    sha256sh_pkg::t_in_word  in_word = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    sha256sh_pkg::t_out_word out_word;

    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_req = 1'b0;
    int items_sent = 0;

    sha256_digest_sb sb = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha256_stream_hasher_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    function automatic sha256sh_pkg::t_in_word mk_word(logic [7:0] d, logic h, logic e);
        sha256sh_pkg::t_in_word wd;
        wd.data_byte   = d;
        wd.has_byte    = h;
        wd.message_end = e;
        return wd;
    endfunction

    task automatic send_word(input sha256sh_pkg::t_in_word wd);
        int gap;
        gap = src_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= wd;
        do @(posedge clk); while (!in_ready);
        sb.note_input(wd);
        if (wd.has_byte || wd.message_end) items_sent++;
    endtask

    task automatic send_message(input int len);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(mk_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_word(mk_word(8'($urandom_range(0, 255)), 1'b1,
                              !split_end && (i == len - 1)));
        end
        if (split_end)
            send_word(mk_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // digest word sink
    initial begin
        int stall;
        stall = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_ready && out_valid) begin
                sb.check_output(out_word);
                stall = sink_gaps ? $urandom_range(0, 6) : 0;
            end
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                stall = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int len;
        int mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(mk_word(8'h00, 1'b0, 1'b1));      // empty message
        send_word(mk_word(8'h61, 1'b1, 1'b0));
        send_word(mk_word(8'h62, 1'b1, 1'b0));
        send_word(mk_word(8'h63, 1'b1, 1'b1));
        send_word(mk_word(8'hff, 1'b0, 1'b0));      // idle word, ignored
        send_word(mk_word(8'hff, 1'b1, 1'b0));
        send_word(mk_word(8'h00, 1'b1, 1'b0));
        send_word(mk_word(8'h5a, 1'b0, 1'b0));
        send_word(mk_word(8'hc3, 1'b0, 1'b1));      // end mark after bytes
        send_word(mk_word(8'h80, 1'b1, 1'b1));
        send_word(mk_word(8'haa, 1'b0, 1'b0));
        send_word(mk_word(8'hff, 1'b0, 1'b1));      // empty again
        drain();

        // sink holds off while messages keep coming
        hold_req = 1'b1;
        src_gaps = 1'b0;
        repeat (3) send_message($urandom_range(0, 10));
        drain();

        while (items_sent < ITEM_TARGET || sb.messages < MSG_TARGET) begin
            mode = $urandom_range(0, 3);
            src_gaps  = (mode == 0) || (mode == 2);
            sink_gaps = (mode == 0) || (mode == 3);
            if ($urandom_range(0, 9) < 3)
                len = EDGE_LENS[$urandom_range(0, 8)];
            else
                len = $urandom_range(0, 20);
            send_message(len);
            if ($urandom_range(0, 3) == 0) drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d input words; %0d digest words checked",
                 sb.messages, items_sent, sb.words_checked);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d digest words outstanding", sb.pending());
        $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sha256sh_pkg.sv
hw/rtl/sha256_stream_hasher_top.sv
hw/rtl/sha256sh_checker.sv
test/tb_top.sv
